@@ sv/bus_frame_receiver_acker_top_macros.svh @@
// Assertion macros used by the checker file of the bus frame receiver.
`ifndef BUS_FRAME_RECEIVER_ACKER_TOP_MACROS_SVH
`define BUS_FRAME_RECEIVER_ACKER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BFRA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bus frame receiver check failed");

// Checks a property on every rising clock edge, reset included.
`define BFRA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bus frame receiver reset check failed");

`endif

@@ sv/bfra_pkg.sv @@
// Types, codes and framing constants of the bus frame receiver.
package bfra_pkg;

    // Framing bytes.
    localparam logic [7:0] HUNT_A   = 8'h00;
    localparam logic [7:0] HUNT_B   = 8'hE9;
    localparam logic [7:0] ACK_SIZE = 8'h7F;

    // Frame lengths: an acknowledge frame is fixed, a data frame is size plus overhead.
    localparam logic [8:0] ACK_LEN   = 9'd5;
    localparam logic [8:0] LEN_EXTRA = 9'd6;

    // Item kinds on the output channel.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ACK    = 1'b1;

    // Position of the current output item within one result group.
    localparam logic [2:0] ACK_POS_STATUS = 3'd0;
    localparam logic [2:0] ACK_POS_HUNT   = 3'd1;
    localparam logic [2:0] ACK_POS_ADDR   = 3'd2;
    localparam logic [2:0] ACK_POS_SIZE   = 3'd3;
    localparam logic [2:0] ACK_POS_SEQ    = 3'd4;
    localparam logic [2:0] ACK_POS_CHECK  = 3'd5;

    // Event reported with each status item.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_DATA_OK   = 3'd1,
        EV_ACK_OK    = 3'd2,
        EV_ECHO_END  = 3'd3,
        EV_PHONE_BAD = 3'd4,
        EV_DISCARD   = 3'd5
    } event_t;

    // Everything the output side needs to know about one received word.
    typedef struct packed {
        logic       byte_valid;
        logic [8:0] byte_index;
        logic [7:0] frame_byte;
        event_t     event_res;
        logic [7:0] tx_sequence;
        logic [7:0] seq_byte;
        logic       has_ack;
    } rx_result_t;

endpackage

@@ sv/bfra_rx.sv @@
// Frame parser: holds the framing state and decodes one received word.
module bfra_rx
    import bfra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output rx_result_t res
);

    logic [8:0] byte_count_reg,    byte_count_next;
    logic [8:0] frame_length_reg,  frame_length_next;
    logic [7:0] running_xor_reg,   running_xor_next;
    logic [7:0] first_byte_reg,    first_byte_next;
    logic [7:0] second_byte_reg,   second_byte_next;
    logic       is_ack_frame_reg,  is_ack_frame_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [7:0] sequence_reg,      sequence_next;

    logic       is_hunt;
    logic [7:0] first_v;
    logic [7:0] second_v;
    logic [8:0] len_v;
    logic       is_ack_v;
    logic [8:0] count_v;
    logic       from_phone;
    logic       good;

    // Values of this word's header fields, including the one it may set itself.
    assign is_hunt  = (rx_byte == HUNT_A) || (rx_byte == HUNT_B);
    assign first_v  = (byte_count_reg == 9'd0) ? rx_byte : first_byte_reg;
    assign second_v = (byte_count_reg == 9'd1) ? rx_byte : second_byte_reg;
    assign is_ack_v = (byte_count_reg == 9'd2) ? (rx_byte == ACK_SIZE) : is_ack_frame_reg;
    assign len_v    = (byte_count_reg != 9'd2) ? frame_length_reg :
                      (rx_byte == ACK_SIZE)    ? ACK_LEN : ({1'b0, rx_byte} + LEN_EXTRA);
    assign count_v    = byte_count_reg + 9'd1;
    assign from_phone = (first_v == HUNT_B) && (second_v == HUNT_A);
    assign good       = (rx_byte == running_xor_reg);

    // Decode of the word and the next framing state.
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        frame_length_next  = frame_length_reg;
        running_xor_next   = running_xor_reg;
        first_byte_next    = first_byte_reg;
        second_byte_next   = second_byte_reg;
        is_ack_frame_next  = is_ack_frame_reg;
        previous_byte_next = previous_byte_reg;
        sequence_next      = sequence_reg;

        res.byte_valid = 1'b1;
        res.byte_index = byte_count_reg;
        res.frame_byte = rx_byte;
        res.event_res  = EV_NONE;
        res.seq_byte   = previous_byte_reg;
        res.has_ack    = 1'b0;

        if ((byte_count_reg == 9'd0) && !is_hunt)
        begin
            // Hunting and the word cannot open a frame.
            res.byte_valid = 1'b0;
            res.byte_index = 9'd0;
            res.frame_byte = 8'h00;
            res.event_res  = EV_DISCARD;
        end
        else if (count_v < len_v)
        begin
            // Word inside the frame.
            first_byte_next    = first_v;
            second_byte_next   = second_v;
            frame_length_next  = len_v;
            is_ack_frame_next  = is_ack_v;
            running_xor_next   = running_xor_reg ^ rx_byte;
            previous_byte_next = rx_byte;
            byte_count_next    = count_v;
        end
        else
        begin
            // Checksum word closes the frame.
            first_byte_next    = first_v;
            second_byte_next   = second_v;
            previous_byte_next = rx_byte;
            byte_count_next    = 9'd0;
            frame_length_next  = ACK_LEN;
            running_xor_next   = 8'h00;
            is_ack_frame_next  = 1'b0;
            if (!from_phone)
            begin
                res.event_res = EV_ECHO_END;
            end
            else if (!good)
            begin
                res.event_res = EV_PHONE_BAD;
            end
            else if (is_ack_v)
            begin
                res.event_res = EV_ACK_OK;
                sequence_next = sequence_reg + 8'd1;
            end
            else
            begin
                res.event_res = EV_DATA_OK;
                res.has_ack   = 1'b1;
            end
        end

        res.tx_sequence = sequence_next;
    end

    // Framing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= 9'd0;
            frame_length_reg  <= ACK_LEN;
            running_xor_reg   <= 8'h00;
            first_byte_reg    <= 8'h00;
            second_byte_reg   <= 8'h00;
            is_ack_frame_reg  <= 1'b0;
            previous_byte_reg <= 8'h00;
            sequence_reg      <= 8'h00;
        end
        else if (take)
        begin
            byte_count_reg    <= byte_count_next;
            frame_length_reg  <= frame_length_next;
            running_xor_reg   <= running_xor_next;
            first_byte_reg    <= first_byte_next;
            second_byte_reg   <= second_byte_next;
            is_ack_frame_reg  <= is_ack_frame_next;
            previous_byte_reg <= previous_byte_next;
            sequence_reg      <= sequence_next;
        end
    end

endmodule

@@ sv/bus_frame_receiver_acker_top.sv @@
// Top level of the bus frame receiver and acknowledger.
//
// Input channel: one received serial word per handshake on rx_byte, taken at a
// rising edge with in_valid high and in_stall low. Output channel: result words,
// each a status word (kind 0) or an acknowledge word to transmit (kind 1), taken
// with out_valid high and out_stall low; last marks the final result of an input.
// Latency: the status word of an input is registered and appears in the cycle after it is taken.
// Throughput: one input per cycle while results are taken at once; an input that
// closes a good data frame yields six result words (status then five acknowledge
// words), so the next input waits until the sixth is taken.
// A new input is taken in the same cycle that the last result of the previous one
// leaves, so single-result inputs stream with no gap.
// While out_stall is high the result words hold and in_stall rises.
// Reset clears the framing state to hunting, the transmit sequence to zero and
// empties the result register.
module bus_frame_receiver_acker_top
    import bfra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic       byte_valid,
    output logic [8:0] byte_index,
    output logic [7:0] frame_byte,
    output logic [2:0] event_res,
    output logic [7:0] tx_sequence,
    output logic [7:0] ack_byte,
    output logic       last
);

    rx_result_t res;
    rx_result_t res_reg;
    logic       out_valid_reg;
    logic [2:0] ack_pos_reg;
    logic       take;
    logic       out_fire;
    logic       is_status;

    // Handshake: a new word enters once the current group is leaving.
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && !(out_fire && last);
    assign take     = in_valid && !in_stall;

    bfra_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .res     (res)
    );

    // Result register and position within the group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ack_pos_reg   <= ACK_POS_STATUS;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            ack_pos_reg   <= ACK_POS_STATUS;
        end
        else if (out_fire && last)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            ack_pos_reg <= ack_pos_reg + 3'd1;
        end
    end

    // Payload of the result register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    // Output word assembly.
    assign is_status   = (ack_pos_reg == ACK_POS_STATUS);
    assign out_valid   = out_valid_reg;
    assign kind        = is_status ? KIND_STATUS : KIND_ACK;
    assign byte_valid  = is_status && res_reg.byte_valid;
    assign byte_index  = is_status ? res_reg.byte_index : 9'd0;
    assign frame_byte  = is_status ? res_reg.frame_byte : 8'h00;
    assign event_res   = is_status ? res_reg.event_res : EV_NONE;
    assign tx_sequence = res_reg.tx_sequence;
    assign last        = !res_reg.has_ack || (ack_pos_reg == ACK_POS_CHECK);

    // Acknowledge frame bytes.
    always_comb
    begin
        case (ack_pos_reg)
            ACK_POS_STATUS: ack_byte = 8'h00;
            ACK_POS_HUNT:   ack_byte = HUNT_A;
            ACK_POS_ADDR:   ack_byte = HUNT_B;
            ACK_POS_SIZE:   ack_byte = ACK_SIZE;
            ACK_POS_SEQ:    ack_byte = res_reg.seq_byte;
            ACK_POS_CHECK:  ack_byte = HUNT_A ^ HUNT_B ^ ACK_SIZE ^ res_reg.seq_byte;
            default:        ack_byte = 8'h00;
        endcase
    end

endmodule

@@ sv/bfra_checker.sv @@
// Port-level checker of the bus frame receiver, bound to the top level.
`include "bus_frame_receiver_acker_top_macros.svh"

module bfra_checker
    import bfra_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic       byte_valid,
    input logic [2:0] event_res,
    input logic [7:0] ack_byte,
    input logic       last
);

    // A stalled result word holds.
    `BFRA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({kind, ack_byte, last}))

    // A good data frame is always followed by acknowledge words.
    `BFRA_ASSERT(a_data_not_last, out_valid && (kind == KIND_STATUS) && (event_res == EV_DATA_OK) |-> !last)

    // Any other status word ends its group.
    `BFRA_ASSERT(a_other_last, out_valid && (kind == KIND_STATUS) && (event_res != EV_DATA_OK) |-> last)

    // Acknowledge words carry no frame word and no event.
    `BFRA_ASSERT(a_ack_clean, out_valid && (kind == KIND_ACK) |-> !byte_valid && (event_res == EV_NONE))

    // Nothing is offered during reset.
    `BFRA_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid)

endmodule

bind bus_frame_receiver_acker_top bfra_checker u_bfra_checker (.*);

@@ tb/bus_frame_receiver_acker_checker.sv @@
// Result checker for the bus frame receiver: predicts every result word and compares it.
`timescale 1ns / 1ps

module bus_frame_receiver_acker_checker
    import bfra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       kind,
    input  logic       byte_valid,
    input  logic [8:0] byte_index,
    input  logic [7:0] frame_byte,
    input  logic [2:0] event_res,
    input  logic [7:0] tx_sequence,
    input  logic [7:0] ack_byte,
    input  logic       last,
    output int         fail_count,
    output int         pending
);

    // One result word as the output channel carries it.
    typedef struct {
        logic       kind;
        logic       byte_valid;
        logic [8:0] byte_index;
        logic [7:0] frame_byte;
        event_t     event_res;
        logic [7:0] tx_sequence;
        logic [7:0] ack_byte;
        logic       last;
    } result_word_t;

    // Framing state of the predicted receiver.
    logic [8:0] frame_pos  = '0;
    logic [8:0] frame_len  = ACK_LEN;
    logic [7:0] frame_xor  = '0;
    logic [7:0] lead_byte  = '0;
    logic [7:0] addr_byte  = '0;
    logic       ack_frame  = 1'b0;
    logic [7:0] prior_byte = '0;
    logic [7:0] tx_seq     = '0;

    result_word_t expected_words[$];
    int errors = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Builds a status word; it always carries the current transmit sequence.
    function automatic result_word_t status_word(logic valid, logic [8:0] idx,
                                                 logic [7:0] fb, event_t ev, logic fin);
        result_word_t w;
        w.kind        = KIND_STATUS;
        w.byte_valid  = valid;
        w.byte_index  = idx;
        w.frame_byte  = fb;
        w.event_res   = ev;
        w.tx_sequence = tx_seq;
        w.ack_byte    = 8'h00;
        w.last        = fin;
        return w;
    endfunction

    // Builds one word of the acknowledge frame sent back to the phone.
    function automatic result_word_t ack_word(logic [7:0] ab, logic fin);
        result_word_t w;
        w.kind        = KIND_ACK;
        w.byte_valid  = 1'b0;
        w.byte_index  = '0;
        w.frame_byte  = '0;
        w.event_res   = EV_NONE;
        w.tx_sequence = tx_seq;
        w.ack_byte    = ab;
        w.last        = fin;
        return w;
    endfunction

    // Advances the framing state by one received word and queues what it causes.
    task automatic predict_rx_word(input logic [7:0] b);
        logic [8:0] idx;
        logic [8:0] count;
        logic [7:0] seq_byte;
        logic [7:0] ack_bytes [5];
        logic       from_phone;
        logic       good;
        logic       was_ack;
        idx = frame_pos;
        if (idx == 0 && b != HUNT_A && b != HUNT_B)
        begin
            expected_words.push_back(status_word(1'b0, '0, '0, EV_DISCARD, 1'b1));
        end
        else
        begin
            if (idx == 0)
                lead_byte = b;
            if (idx == 1)
                addr_byte = b;
            if (idx == 2)
            begin
                ack_frame = (b == ACK_SIZE);
                frame_len = (b == ACK_SIZE) ? ACK_LEN : {1'b0, b} + LEN_EXTRA;
            end
            count = idx + 9'd1;
            if (count < frame_len)
            begin
                frame_xor  = frame_xor ^ b;
                prior_byte = b;
                frame_pos  = count;
                expected_words.push_back(status_word(1'b1, idx, b, EV_NONE, 1'b1));
            end
            else
            begin
                // Last word of the frame: judge it, then go back to hunting.
                seq_byte   = prior_byte;
                from_phone = (lead_byte == HUNT_B) && (addr_byte == HUNT_A);
                good       = (b == frame_xor);
                was_ack    = ack_frame;
                prior_byte = b;
                frame_pos  = '0;
                frame_len  = ACK_LEN;
                frame_xor  = '0;
                ack_frame  = 1'b0;
                if (!from_phone)
                    expected_words.push_back(status_word(1'b1, idx, b, EV_ECHO_END, 1'b1));
                else if (!good)
                    expected_words.push_back(status_word(1'b1, idx, b, EV_PHONE_BAD, 1'b1));
                else if (was_ack)
                begin
                    tx_seq = tx_seq + 8'd1;
                    expected_words.push_back(status_word(1'b1, idx, b, EV_ACK_OK, 1'b1));
                end
                else
                begin
                    expected_words.push_back(status_word(1'b1, idx, b, EV_DATA_OK, 1'b0));
                    ack_bytes[0] = HUNT_A;
                    ack_bytes[1] = lead_byte;
                    ack_bytes[2] = ACK_SIZE;
                    ack_bytes[3] = seq_byte;
                    ack_bytes[4] = ack_bytes[0] ^ ack_bytes[1] ^ ack_bytes[2] ^ ack_bytes[3];
                    for (int i = 0; i < 5; i++)
                        expected_words.push_back(ack_word(ack_bytes[i], i == 4));
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Compares the word on the output channel with the oldest expectation.
    task automatic check_result_word();
        result_word_t w;
        if (expected_words.size() == 0)
        begin
            $error("result word arrived with no expectation waiting");
            errors++;
        end
        else
        begin
            w = expected_words.pop_front();
            compare_field("kind", w.kind, kind);
            compare_field("byte_valid", w.byte_valid, byte_valid);
            compare_field("byte_index", w.byte_index, byte_index);
            compare_field("frame_byte", w.frame_byte, frame_byte);
            compare_field("event_res", w.event_res, event_res);
            compare_field("tx_sequence", w.tx_sequence, tx_sequence);
            compare_field("ack_byte", w.ack_byte, ack_byte);
            compare_field("last", w.last, last);
        end
    endtask

    // Watch both channels at every edge; inputs are taken before outputs are checked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos  = '0;
            frame_len  = ACK_LEN;
            frame_xor  = '0;
            lead_byte  = '0;
            addr_byte  = '0;
            ack_frame  = 1'b0;
            prior_byte = '0;
            tx_seq     = '0;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_rx_word(rx_byte);
            if (out_valid && !out_stall)
                check_result_word();
            fail_count <= errors;
            pending    <= expected_words.size();
        end
    end

endmodule

@@ tb/bus_frame_receiver_acker_top_tb.sv @@
// Testbench top for the bus frame receiver: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps

module bus_frame_receiver_acker_top_tb;
    import bfra_pkg::*;

    // Watchdog limit on the run length, with a wide margin over the slowest run.
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b1;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       kind;
    logic       byte_valid;
    logic [8:0] byte_index;
    logic [7:0] frame_byte;
    logic [2:0] event_res;
    logic [7:0] tx_sequence;
    logic [7:0] ack_byte;
    logic       last;

    int          fail_count;
    int          pending;
    int          words_taken = 0;
    int          burst_left  = 1;
    int unsigned cycle_count = 0;

    bus_frame_receiver_acker_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_valid  (byte_valid),
        .byte_index  (byte_index),
        .frame_byte  (frame_byte),
        .event_res   (event_res),
        .tx_sequence (tx_sequence),
        .ack_byte    (ack_byte),
        .last        (last)
    );

    bus_frame_receiver_acker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_valid  (byte_valid),
        .byte_index  (byte_index),
        .frame_byte  (frame_byte),
        .event_res   (event_res),
        .tx_sequence (tx_sequence),
        .ack_byte    (ack_byte),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one word and holds it until the block takes it; then maybe pauses.
    task automatic put_word(input logic [7:0] w);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_taken++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long burst with no idle cycles at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Sends one frame with random body; corrupt spoils its checksum word.
    task automatic send_frame(input logic [7:0] lead, input logic [7:0] addr,
                              input logic [7:0] size, input bit corrupt);
        int         len;
        logic [7:0] chk;
        logic [7:0] w;
        len = (size == ACK_SIZE) ? int'(ACK_LEN) : int'(size) + int'(LEN_EXTRA);
        chk = 8'h00;
        for (int i = 0; i < len - 1; i++)
        begin
            if (i == 0)
                w = lead;
            else if (i == 1)
                w = addr;
            else if (i == 2)
                w = size;
            else
                w = 8'($urandom_range(0, 255));
            chk = chk ^ w;
            put_word(w);
        end
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        put_word(chk);
    endtask

    // Receiver stalls in changing patterns, with one long hold-off to fill the block.
    initial
    begin
        int mode;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && words_taken >= 60)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            repeat (24)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ~out_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus: directed frames, random traffic with one largest frame, then the verdict.
    initial
    begin
        int         start;
        int         r;
        bit         big_done;
        logic [7:0] lead;
        logic [7:0] addr;
        logic [7:0] size;
        logic [7:0] w;

        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise while hunting, then one frame of each outcome.
        put_word(8'hFF);
        put_word(8'h01);
        put_word(8'h80);
        send_frame(HUNT_B, HUNT_A, ACK_SIZE, 1'b0);
        send_frame(HUNT_B, HUNT_A, 8'h00, 1'b0);
        send_frame(HUNT_B, HUNT_A, ACK_SIZE, 1'b1);
        send_frame(HUNT_A, HUNT_B, ACK_SIZE, 1'b0);

        // Random traffic, mostly well-formed frames; one frame of the largest size.
        start    = words_taken;
        big_done = 1'b0;
        while (words_taken < 380)
        begin
            if (!big_done && words_taken - start >= 40)
            begin
                send_frame(HUNT_B, HUNT_A, 8'hFF, 1'b0);
                big_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                send_frame(HUNT_B, HUNT_A, 8'($urandom_range(0, 12)), 1'b0);
            else if (r < 60)
                send_frame(HUNT_B, HUNT_A, ACK_SIZE, 1'b0);
            else if (r < 70)
            begin
                size = $urandom_range(0, 1) ? ACK_SIZE : 8'($urandom_range(0, 12));
                send_frame(HUNT_B, HUNT_A, size, 1'b1);
            end
            else if (r < 82)
            begin
                // Frames not from the phone end as echoes.
                lead = $urandom_range(0, 1) ? HUNT_B : HUNT_A;
                addr = 8'($urandom_range(0, 255));
                if (lead == HUNT_B && addr == HUNT_A)
                    addr = 8'h01;
                size = ($urandom_range(0, 2) == 0) ? ACK_SIZE : 8'($urandom_range(0, 10));
                send_frame(lead, addr, size, 1'($urandom_range(0, 1)));
            end
            else
            begin
                // Line noise; an occasional stray opener breaks the next frame.
                repeat ($urandom_range(1, 4))
                begin
                    w = 8'($urandom_range(1, 255));
                    if (w == HUNT_B && $urandom_range(0, 3) != 0)
                        w = 8'h5A;
                    put_word(w);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
